>>> sv/mlfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

    // Default sizing of the queue store
    localparam int LINES_DEF      = 8;
    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int FUNC_W   = 1;
    localparam int LINE_IN_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

endpackage

`default_nettype wire

>>> sv/multi_line_fifo_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Several FIFO lines sharing one linked-list entry store.
// Command channel: a beat is taken at a clock edge with start high and busy low;
// func selects append (value to the tail of line) or pop (head of line).
// Result channel: done is high for exactly one cycle per command and carries
// popped_value, status, line_count and all_empty. The receiver cannot stall;
// a result is shown once and must be taken in that cycle.
// Timing: in the accept cycle the next-pointer and data memories are read at the
// line head or the free-list head; in the following cycle (busy high) the read
// data comes back and the pointer state and memories are written. done rises in
// the cycle after that, when busy is already low, so a new command may be accepted
// in the same cycle as the previous result. A new command is held off while busy,
// since the registered read of the pointer memory comes ahead of its write-back.
// Reads and writes of one entry never overlap, since busy holds off the next
// command during the write cycle.
// Reset: all lines empty, free list empty, fresh region starts at entry zero;
// no clearing pass is needed and commands are taken right after reset.

module multi_line_fifo_queue #(
    parameter int LINES      = mlfq_pkg::LINES_DEF,
    parameter int DEPTH      = mlfq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mlfq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [mlfq_pkg::FUNC_W-1:0]     func,
    input  wire logic [mlfq_pkg::LINE_IN_W-1:0]  line,
    input  wire logic [mlfq_pkg::VALUE_W-1:0]    value,
    output logic                                 done,
    output logic [mlfq_pkg::VALUE_W-1:0]         popped_value,
    output logic [mlfq_pkg::STATUS_W-1:0]        status,
    output logic [mlfq_pkg::COUNT_W-1:0]         line_count,
    output logic                                 all_empty
);

    localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Per-line pointers and counts
    logic [PTR_W-1:0] head_reg [LINES];
    logic [PTR_W-1:0] tail_reg [LINES];
    logic [CNT_W-1:0] len_reg  [LINES];

    // Free list and fresh region
    logic [PTR_W-1:0] free_head_reg, free_head_next;
    logic [CNT_W-1:0] free_len_reg, free_len_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;

    // Captured command
    logic [mlfq_pkg::FUNC_W-1:0] func_reg;
    logic                        in_range_reg;
    logic [LINE_W-1:0]           idx_reg;
    logic [DATA_WIDTH-1:0]       value_reg;
    logic [PTR_W-1:0]            head_cap_reg;
    logic [PTR_W-1:0]            tail_cap_reg;
    logic [CNT_W-1:0]            len_cap_reg;

    // Result registers
    logic                          done_reg;
    logic [mlfq_pkg::VALUE_W-1:0]  popped_reg, popped_next;
    mlfq_pkg::status_t             status_reg, status_next;
    logic [mlfq_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                          empty_reg, empty_next;

    // Per-line write-back
    logic             line_we;
    logic [PTR_W-1:0] head_new, tail_new;
    logic [CNT_W-1:0] len_new;

    // Memory ports
    logic                  nxt_we, dat_we;
    logic [PTR_W-1:0]      nxt_waddr, nxt_wdata, nxt_raddr, nxt_rdata;
    logic [PTR_W-1:0]      dat_waddr, dat_raddr;
    logic [DATA_WIDTH-1:0] dat_rdata;

    // Command decode in the accept cycle
    logic              accept;
    logic              in_ok;
    logic [LINE_W-1:0] in_idx;
    logic [PTR_W-1:0]  head_in, tail_in;
    logic [CNT_W-1:0]  len_in;

    // Execute cycle decode
    logic             has_free, has_fresh, is_pop, is_append;
    logic [PTR_W-1:0] slot;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);
    assign in_ok  = 32'(line) < LINES;
    assign in_idx = LINE_W'(line);

    always_comb
    begin
        head_in = '0;
        tail_in = '0;
        len_in  = '0;
        if (in_ok)
        begin
            head_in = head_reg[in_idx];
            tail_in = tail_reg[in_idx];
            len_in  = len_reg[in_idx];
        end
    end

    // Read the line head for a pop, the free-list head for an append
    assign nxt_raddr = (func == mlfq_pkg::FUNC_POP) ? head_in : free_head_reg;
    assign dat_raddr = head_in;

    mlfq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    mlfq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (dat_waddr),
        .wdata (value_reg),
        .raddr (dat_raddr),
        .rdata (dat_rdata)
    );

    // Execute: update pointers and write back the memories
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        free_len_next  = free_len_reg;
        fresh_next     = fresh_reg;
        popped_next    = '0;
        status_next    = mlfq_pkg::STAT_OK;
        line_we        = 1'b0;
        head_new       = head_cap_reg;
        tail_new       = tail_cap_reg;
        len_new        = len_cap_reg;
        nxt_we         = 1'b0;
        nxt_waddr      = head_cap_reg;
        nxt_wdata      = free_head_reg;
        dat_we         = 1'b0;

        is_pop    = (func_reg == mlfq_pkg::FUNC_POP);
        is_append = (func_reg == mlfq_pkg::FUNC_APPEND);
        has_free  = (free_len_reg != '0);
        has_fresh = (fresh_reg < CNT_W'(DEPTH));
        slot      = has_free ? free_head_reg : PTR_W'(fresh_reg);
        dat_waddr = slot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                if (!in_range_reg)
                begin
                    status_next = is_append ? mlfq_pkg::STAT_FULL : mlfq_pkg::STAT_EMPTY;
                end
                else if (is_append)
                begin
                    if (has_free || has_fresh)
                    begin
                        dat_we  = 1'b1;
                        line_we = 1'b1;
                        tail_new = slot;
                        len_new  = len_cap_reg + CNT_W'(1);
                        if (len_cap_reg == '0)
                        begin
                            head_new = slot;
                        end
                        else
                        begin
                            // link the old tail to the new entry
                            nxt_we    = 1'b1;
                            nxt_waddr = tail_cap_reg;
                            nxt_wdata = slot;
                        end
                        if (has_free)
                        begin
                            free_head_next = nxt_rdata;
                            free_len_next  = free_len_reg - CNT_W'(1);
                        end
                        else
                        begin
                            fresh_next = fresh_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        status_next = mlfq_pkg::STAT_FULL;
                    end
                end
                else if (is_pop)
                begin
                    if (len_cap_reg == '0)
                    begin
                        status_next = mlfq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        // hand the head entry back to the free list
                        popped_next    = mlfq_pkg::VALUE_W'(dat_rdata);
                        line_we        = 1'b1;
                        head_new       = nxt_rdata;
                        len_new        = len_cap_reg - CNT_W'(1);
                        nxt_we         = 1'b1;
                        nxt_waddr      = head_cap_reg;
                        nxt_wdata      = free_head_reg;
                        free_head_next = head_cap_reg;
                        free_len_next  = free_len_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_next = in_range_reg ? mlfq_pkg::COUNT_W'(len_new) : '0;
        // entries in use are the fresh ones handed out less the recycled ones
        empty_next = (fresh_next == free_len_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            free_len_reg  <= '0;
            fresh_reg     <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < LINES; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            free_len_reg  <= free_len_next;
            fresh_reg     <= fresh_next;
            done_reg      <= (state_reg == S_EXEC);
            if (line_we)
            begin
                len_reg[idx_reg] <= len_new;
            end
        end
    end

    // Capture the command, hold per-line pointers and the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            in_range_reg <= in_ok;
            idx_reg      <= in_idx;
            value_reg    <= DATA_WIDTH'(value);
            head_cap_reg <= head_in;
            tail_cap_reg <= tail_in;
            len_cap_reg  <= len_in;
        end
        if (line_we)
        begin
            head_reg[idx_reg] <= head_new;
            tail_reg[idx_reg] <= tail_new;
        end
        if (state_reg == S_EXEC)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
            count_reg  <= count_next;
            empty_reg  <= empty_next;
        end
    end

    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign line_count   = count_reg;
    assign all_empty    = empty_reg;

endmodule

`default_nettype wire

>>> sv/mlfq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mlfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/mlfq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mlfq_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            done,
    input wire logic [mlfq_pkg::VALUE_W-1:0]    popped_value,
    input wire logic [mlfq_pkg::STATUS_W-1:0]   status,
    input wire logic [mlfq_pkg::COUNT_W-1:0]    line_count,
    input wire logic                            all_empty
);

    // Every accepted command raises busy and then gives one beat
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("result beat missing after execute cycle");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a command");

    // A failed command returns no data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != mlfq_pkg::STAT_OK) |-> popped_value == '0)
        else $error("failed command returned data");

    // An empty store leaves the addressed line empty
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && all_empty |-> line_count == '0)
        else $error("line count nonzero with all lines empty");

endmodule

bind multi_line_fifo_queue mlfq_checker u_mlfq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .line_count   (line_count),
    .all_empty    (all_empty)
);

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
    import mlfq_pkg::*;

    localparam int NLINES      = LINES_DEF;
    localparam int NSLOTS      = DEPTH_DEF;
    localparam int RANDOM_CMDS = 1950;
    localparam int STALL_LIMIT = 1000;

    typedef enum int {PH_FILL, PH_MIX_A, PH_DRAIN, PH_MIX_B} phase_t;

    // Expected contents of one result beat
    typedef struct {
        logic [VALUE_W-1:0] popped_value;
        status_t            status;
        logic [COUNT_W-1:0] line_count;
        logic               all_empty;
    } queue_result_t;

    // Tracks the shared linked-list store and checks each result beat in order
    class line_store_tracker;
        bit [7:0]         head_idx [NLINES];
        bit [7:0]         tail_idx [NLINES];
        bit [COUNT_W-1:0] fill     [NLINES];
        bit [7:0]         link     [NSLOTS];
        bit [VALUE_W-1:0] word     [NSLOTS];
        bit [7:0]         free_top;
        int               free_cnt;
        int               fresh_idx;
        int               occupancy;
        queue_result_t    awaited [$];
        int               mismatches;
        int               appends_ok, pops_ok, empty_pops, full_appends, peak_line;

        function new();
            foreach (fill[k]) fill[k] = '0;
            free_top  = '0;
            free_cnt  = 0;
            fresh_idx = 0;
            occupancy = 0;
        endfunction

        // Apply one accepted command to the store and queue its result
        function void note_command(logic [FUNC_W-1:0] f, logic [LINE_IN_W-1:0] l,
                                   logic [VALUE_W-1:0] v);
            queue_result_t r;
            bit [7:0]      e;
            bit            got;
            r.popped_value = '0;
            r.status       = STAT_OK;
            got            = 1'b0;
            if (f == FUNC_APPEND) begin
                // take a recycled entry first, then a fresh one
                if (free_cnt != 0) begin
                    e        = free_top;
                    free_top = link[e];
                    free_cnt--;
                    got      = 1'b1;
                end else if (fresh_idx < NSLOTS) begin
                    e = fresh_idx[7:0];
                    fresh_idx++;
                    got = 1'b1;
                end
                if (got) begin
                    word[e] = v;
                    link[e] = '0;
                    if (fill[l] == 0)
                        head_idx[l] = e;
                    else
                        link[tail_idx[l]] = e;
                    tail_idx[l] = e;
                    fill[l]++;
                    occupancy++;
                    appends_ok++;
                end else begin
                    r.status = STAT_FULL;
                    full_appends++;
                end
            end else begin
                if (fill[l] == 0) begin
                    r.status = STAT_EMPTY;
                    empty_pops++;
                end else begin
                    // unlink the head and push it onto the free list
                    e              = head_idx[l];
                    r.popped_value = word[e];
                    head_idx[l]    = link[e];
                    fill[l]--;
                    occupancy--;
                    link[e]  = free_top;
                    free_top = e;
                    free_cnt++;
                    pops_ok++;
                end
            end
            r.line_count = fill[l];
            r.all_empty  = (occupancy == 0);
            if (int'(fill[l]) > peak_line) peak_line = int'(fill[l]);
            awaited.push_back(r);
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        // Compare a result beat with the oldest expectation
        function void check_result(logic [VALUE_W-1:0] pv, logic [STATUS_W-1:0] st,
                                   logic [COUNT_W-1:0] cnt, logic ae);
            queue_result_t r;
            if (awaited.size() == 0) begin
                report($sformatf("result with nothing pending: value %h status %0d count %0d",
                                 pv, st, cnt));
                return;
            end
            r = awaited.pop_front();
            if (pv !== r.popped_value || st !== r.status || cnt !== r.line_count
                || ae !== r.all_empty)
                report($sformatf({"expected value %h status %0d count %0d empty %b, ",
                                  "got value %h status %0d count %0d empty %b"},
                                 r.popped_value, r.status, r.line_count, r.all_empty,
                                 pv, st, cnt, ae));
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [FUNC_W-1:0]    func = FUNC_APPEND;
    logic [LINE_IN_W-1:0] line = '0;
    logic [VALUE_W-1:0]   value = '0;
    logic                 busy;
    logic                 done;
    logic [VALUE_W-1:0]   popped_value;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   line_count;
    logic                 all_empty;

    line_store_tracker store = new();
    int                burst_left = 1;
    int                stall_cycles = 0;

    multi_line_fifo_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .line         (line),
        .value        (value),
        .done         (done),
        .popped_value (popped_value),
        .status       (status),
        .line_count   (line_count),
        .all_empty    (all_empty)
    );

    always #5 clk = ~clk;

    // Record accepted beats on both sides; stop on a long stall
    always @(posedge clk) begin
        if (rst_n) begin
            if (done) store.check_result(popped_value, status, line_count, all_empty);
            if (start && !busy) store.note_command(func, line, value);
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Hold one command until it is taken; return at the next falling edge
    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [LINE_IN_W-1:0] l,
                            input logic [VALUE_W-1:0] v);
        start = 1'b1;
        func  = f;
        line  = l;
        value = v;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        @(negedge clk);
    endtask

    // End a burst now and then and idle for a random gap
    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            if (gap != 0) begin
                start = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    initial begin
        phase_t               phase;
        int                   sent;
        int                   phase_items;
        int                   extra;
        int                   round;
        int                   append_pct;
        int                   hot_pct;
        logic [LINE_IN_W-1:0] hot_line;
        logic [FUNC_W-1:0]    f;
        logic [LINE_IN_W-1:0] l;
        logic [VALUE_W-1:0]   v;

        // hold reset, then release it away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty pops, value extremes, outer lines, recycled entries
        send_cmd(FUNC_POP,    3'd0, 32'h0000_0000);
        send_cmd(FUNC_POP,    3'd7, 32'hFFFF_FFFF);
        send_cmd(FUNC_APPEND, 3'd0, 32'h0000_0000);
        send_cmd(FUNC_APPEND, 3'd7, 32'hFFFF_FFFF);
        send_cmd(FUNC_APPEND, 3'd0, 32'h8000_0001);
        send_cmd(FUNC_APPEND, 3'd3, 32'h5A5A_A5A5);
        send_cmd(FUNC_POP,    3'd7, 32'h0000_0000);
        send_cmd(FUNC_POP,    3'd7, 32'h0000_0000);
        send_cmd(FUNC_POP,    3'd0, 32'h1234_5678);
        send_cmd(FUNC_POP,    3'd0, 32'h0000_0000);
        send_cmd(FUNC_POP,    3'd3, 32'h0000_0000);
        send_cmd(FUNC_APPEND, 3'd5, 32'h0000_0001);
        send_cmd(FUNC_APPEND, 3'd5, 32'h7FFF_FFFF);
        send_cmd(FUNC_APPEND, 3'd2, 32'hA5A5_5A5A);
        send_cmd(FUNC_POP,    3'd5, 32'h0000_0000);
        send_cmd(FUNC_POP,    3'd2, 32'h0000_0000);
        send_cmd(FUNC_POP,    3'd5, 32'h0000_0000);
        send_cmd(FUNC_POP,    3'd4, 32'h0000_0000);

        // random: fill the store to full, mix, drain to empty, mix, repeat
        phase       = PH_FILL;
        phase_items = 0;
        extra       = 0;
        round       = 0;
        hot_line    = LINE_IN_W'($urandom_range(0, NLINES - 1));
        for (sent = 0; sent < RANDOM_CMDS; sent++) begin
            case (phase)
                PH_FILL:  begin append_pct = 95; hot_pct = (round == 0) ? 100 : 60; end
                PH_DRAIN: begin append_pct = 10; hot_pct = 40; end
                default:  begin append_pct = 50; hot_pct = 20; end
            endcase
            f = ($urandom_range(0, 99) < append_pct) ? FUNC_APPEND : FUNC_POP;
            l = ($urandom_range(0, 99) < hot_pct) ? hot_line
                                                  : LINE_IN_W'($urandom_range(0, NLINES - 1));
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                default: v = $urandom;
            endcase
            send_cmd(f, l, v);
            pace_sender();

            // advance the phase once its goal is met
            phase_items++;
            case (phase)
                PH_FILL:  if (store.occupancy == NSLOTS && ++extra > 8) phase = PH_MIX_A;
                PH_DRAIN: if (store.occupancy == 0 && ++extra > 6) phase = PH_MIX_B;
                default:  if (phase_items >= 150) phase = (phase == PH_MIX_A) ? PH_DRAIN
                                                                              : PH_FILL;
            endcase
            if (phase_items > 0 && (extra > 8 || (extra > 6 && phase == PH_MIX_B)
                                   || phase_items >= 150)) begin
                if (phase == PH_FILL) round++;
                phase_items = 0;
                extra       = 0;
                hot_line    = LINE_IN_W'($urandom_range(0, NLINES - 1));
            end
        end
        start = 1'b0;

        // drain outstanding results, then allow for stray beats
        while (store.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d appends, %0d pops, %0d pops on empty lines, %0d appends refused",
                 store.appends_ok, store.pops_ok, store.empty_pops, store.full_appends);
        $display("deepest line held %0d entries; %0d mismatches",
                 store.peak_line, store.mismatches);
        if (store.mismatches == 0 && store.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/mlfq_pkg.sv
sv/mlfq_ram.sv
sv/multi_line_fifo_queue.sv
sv/mlfq_checker.sv
test/tb.sv
